>>> design/pgsg_pkg.sv
// Package for the polar Gaussian sample generator: shared types and constants.
`default_nettype none
package pgsg_pkg;

  // ln 2 in units of 2^-30
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam int          SQ_STAGES   = 24;
  localparam int          DIV_STAGES  = 32;
  localparam int          SQRT_STAGES = 16;
  localparam logic [16:0] Z_MAX       = 17'd32767;
  localparam logic signed [19:0] SAMPLE_MIN = -20'sd262144;
  localparam logic signed [19:0] SAMPLE_MAX = 20'sd262143;

  // Register indexes on the configuration port
  localparam logic CFG_STD_DEV = 1'b0;
  localparam logic CFG_MEAN    = 1'b1;

  // Per-pair values that ride alongside the log pipeline
  typedef struct packed {
    logic [29:0] sq_a;
    logic [29:0] sq_b;
    logic        neg_a;
    logic        neg_b;
    logic [29:0] s;
  } side_t;

endpackage
`default_nettype wire

>>> design/pgsg_log.sv
// Normalize s and compute -ln(s) in units of 2^-24 over a pipeline of stages.
`default_nettype none
module pgsg_log import pgsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire side_t       in_side,
  output logic             out_vld,
  output side_t            out_side,
  output logic [28:0]      out_l
);

  // Coarse normalize: shifts of 16 and 8
  logic        n1_vld_r;
  side_t       n1_side_r;
  logic [29:0] n1_m_r;
  logic [4:0]  n1_sh_r;
  logic [29:0] n1_m_nxt;
  logic [4:0]  n1_sh_nxt;

  always_comb begin
    n1_m_nxt  = in_side.s;
    n1_sh_nxt = 5'd0;
    if (n1_m_nxt[29:14] == 16'd0) begin
      n1_m_nxt  = {n1_m_nxt[13:0], 16'd0};
      n1_sh_nxt = 5'd16;
    end
    if (n1_m_nxt[29:22] == 8'd0) begin
      n1_m_nxt  = {n1_m_nxt[21:0], 8'd0};
      n1_sh_nxt = n1_sh_nxt + 5'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
    end else if (en) begin
      n1_vld_r <= in_vld;
    end
    if (en) begin
      n1_side_r <= in_side;
      n1_m_r    <= n1_m_nxt;
      n1_sh_r   <= n1_sh_nxt;
    end
  end

  // Fine normalize: shifts of 4, 2 and 1
  logic [29:0] n2_m_nxt;
  logic [4:0]  n2_sh_nxt;

  always_comb begin
    n2_m_nxt  = n1_m_r;
    n2_sh_nxt = n1_sh_r;
    if (n2_m_nxt[29:26] == 4'd0) begin
      n2_m_nxt  = {n2_m_nxt[25:0], 4'd0};
      n2_sh_nxt = n2_sh_nxt + 5'd4;
    end
    if (n2_m_nxt[29:28] == 2'd0) begin
      n2_m_nxt  = {n2_m_nxt[27:0], 2'd0};
      n2_sh_nxt = n2_sh_nxt + 5'd2;
    end
    if (!n2_m_nxt[29]) begin
      n2_m_nxt  = {n2_m_nxt[28:0], 1'b0};
      n2_sh_nxt = n2_sh_nxt + 5'd1;
    end
  end

  // Squaring chain; index 0 holds the normalized mantissa
  logic        sq_vld_r  [0:SQ_STAGES];
  side_t       sq_side_r [0:SQ_STAGES];
  logic [30:0] sq_m_r    [0:SQ_STAGES];
  logic [23:0] sq_f_r    [0:SQ_STAGES];
  logic [4:0]  sq_sh_r   [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= n1_vld_r;
    end
    if (en) begin
      sq_side_r[0] <= n1_side_r;
      sq_m_r[0]    <= {n2_m_nxt, 1'b0};
      sq_f_r[0]    <= 24'd0;
      sq_sh_r[0]   <= n2_sh_nxt;
    end
  end

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] top;
    assign prod = sq_m_r[i] * sq_m_r[i];
    assign top  = prod[61:30];

    // Square, renormalize, shift one fraction bit in
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
      if (en) begin
        sq_side_r[i+1] <= sq_side_r[i];
        sq_sh_r[i+1]   <= sq_sh_r[i];
        if (top[31]) begin
          sq_m_r[i+1] <= top[31:1];
          sq_f_r[i+1] <= {sq_f_r[i][22:0], 1'b1};
        end else begin
          sq_m_r[i+1] <= top[30:0];
          sq_f_r[i+1] <= {sq_f_r[i][22:0], 1'b0};
        end
      end
    end
  end

  // -log2(s), then scale by ln 2, then round
  logic        g_vld_r, p_vld_r, l_vld_r;
  side_t       g_side_r, p_side_r, l_side_r;
  logic [28:0] g_r;
  logic [58:0] p_r;
  logic [28:0] l_r;
  logic [4:0]  g_int;
  logic [59:0] l_sum;

  assign g_int = sq_sh_r[SQ_STAGES] + 5'd1;
  assign l_sum = {1'b0, p_r} + 60'd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      l_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= sq_vld_r[SQ_STAGES];
      p_vld_r <= g_vld_r;
      l_vld_r <= p_vld_r;
    end
    if (en) begin
      g_side_r <= sq_side_r[SQ_STAGES];
      g_r      <= {g_int, 24'd0} - {5'd0, sq_f_r[SQ_STAGES]};
      p_side_r <= g_side_r;
      p_r      <= g_r * LN2_Q30;
      l_side_r <= p_side_r;
      l_r      <= l_sum[58:30];
    end
  end

  assign out_vld  = l_vld_r;
  assign out_side = l_side_r;
  assign out_l    = l_r;

endmodule
`default_nettype wire

>>> design/pgsg_lane.sv
// One output lane: divide by s, square root, round, scale and offset.
`default_nettype none
module pgsg_lane import pgsg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic [29:0]        in_sq,
  input  wire logic               in_neg,
  input  wire logic [29:0]        in_s,
  input  wire logic [28:0]        in_l,
  input  wire logic [11:0]        std_dev,
  input  wire logic signed [17:0] mean_offset,
  output logic                    out_vld,
  output logic signed [15:0]      out_z,
  output logic signed [18:0]      out_smp
);

  // Numerator x*x*L (times 8 by wiring)
  logic        n_vld_r;
  logic        n_neg_r;
  logic [29:0] n_s_r;
  logic [58:0] n_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (en) begin
      n_vld_r <= in_vld;
    end
    if (en) begin
      n_neg_r <= in_neg;
      n_s_r   <= in_s;
      n_num_r <= in_sq * in_l;
    end
  end

  // Restoring divider, one quotient bit per stage
  logic        dv_vld_in [0:DIV_STAGES-1];
  logic        dv_neg_in [0:DIV_STAGES-1];
  logic [29:0] dv_s_in   [0:DIV_STAGES-1];
  logic [29:0] dv_rem_in [0:DIV_STAGES-1];
  logic [31:0] dv_lo_in  [0:DIV_STAGES-1];
  logic [31:0] dv_q_in   [0:DIV_STAGES-1];
  logic        dv_vld_r  [0:DIV_STAGES-1];
  logic        dv_neg_r  [0:DIV_STAGES-1];
  logic [29:0] dv_s_r    [0:DIV_STAGES-1];
  logic [29:0] dv_rem_r  [0:DIV_STAGES-1];
  logic [31:0] dv_lo_r   [0:DIV_STAGES-1];
  logic [31:0] dv_q_r    [0:DIV_STAGES-1];

  assign dv_vld_in[0] = n_vld_r;
  assign dv_neg_in[0] = n_neg_r;
  assign dv_s_in[0]   = n_s_r;
  assign dv_rem_in[0] = n_num_r[58:29];
  assign dv_lo_in[0]  = {n_num_r[28:0], 3'd0};
  assign dv_q_in[0]   = 32'd0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [30:0] t;
    logic        ge;
    if (i > 0) begin : g_link
      assign dv_vld_in[i] = dv_vld_r[i-1];
      assign dv_neg_in[i] = dv_neg_r[i-1];
      assign dv_s_in[i]   = dv_s_r[i-1];
      assign dv_rem_in[i] = dv_rem_r[i-1];
      assign dv_lo_in[i]  = dv_lo_r[i-1];
      assign dv_q_in[i]   = dv_q_r[i-1];
    end
    assign t  = {dv_rem_in[i], dv_lo_in[i][31]};
    assign ge = t >= {1'b0, dv_s_in[i]};

    // Shift in a numerator bit, subtract when it fits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[i] <= 1'b0;
      end else if (en) begin
        dv_vld_r[i] <= dv_vld_in[i];
      end
      if (en) begin
        dv_neg_r[i] <= dv_neg_in[i];
        dv_s_r[i]   <= dv_s_in[i];
        dv_lo_r[i]  <= {dv_lo_in[i][30:0], 1'b0};
        dv_q_r[i]   <= {dv_q_in[i][30:0], ge};
        if (ge) begin
          dv_rem_r[i] <= 30'(t - {1'b0, dv_s_in[i]});
        end else begin
          dv_rem_r[i] <= t[29:0];
        end
      end
    end
  end

  // Digit-by-digit square root, one result bit per stage
  logic        rt_vld_in [0:SQRT_STAGES-1];
  logic        rt_neg_in [0:SQRT_STAGES-1];
  logic [31:0] rt_x_in   [0:SQRT_STAGES-1];
  logic [31:0] rt_r_in   [0:SQRT_STAGES-1];
  logic        rt_vld_r  [0:SQRT_STAGES-1];
  logic        rt_neg_r  [0:SQRT_STAGES-1];
  logic [31:0] rt_x_r    [0:SQRT_STAGES-1];
  logic [31:0] rt_r_r    [0:SQRT_STAGES-1];

  assign rt_vld_in[0] = dv_vld_r[DIV_STAGES-1];
  assign rt_neg_in[0] = dv_neg_r[DIV_STAGES-1];
  assign rt_x_in[0]   = dv_q_r[DIV_STAGES-1];
  assign rt_r_in[0]   = 32'd0;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam logic [31:0] Bit = 32'h4000_0000 >> (2 * j);
    logic [32:0] trial;
    logic        fit;
    if (j > 0) begin : g_link
      assign rt_vld_in[j] = rt_vld_r[j-1];
      assign rt_neg_in[j] = rt_neg_r[j-1];
      assign rt_x_in[j]   = rt_x_r[j-1];
      assign rt_r_in[j]   = rt_r_r[j-1];
    end
    assign trial = {1'b0, rt_r_in[j]} + {1'b0, Bit};
    assign fit   = {1'b0, rt_x_in[j]} >= trial;

    // Take the trial value when it fits under the remainder
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[j] <= 1'b0;
      end else if (en) begin
        rt_vld_r[j] <= rt_vld_in[j];
      end
      if (en) begin
        rt_neg_r[j] <= rt_neg_in[j];
        if (fit) begin
          rt_x_r[j] <= rt_x_in[j] - trial[31:0];
          rt_r_r[j] <= (rt_r_in[j] >> 1) + Bit;
        end else begin
          rt_x_r[j] <= rt_x_in[j];
          rt_r_r[j] <= rt_r_in[j] >> 1;
        end
      end
    end
  end

  // Round the root to Q4.12, saturate, apply sign
  logic               z_vld_r;
  logic signed [15:0] z_r;
  logic [17:0]        z_inc;
  logic [16:0]        z_mag;
  logic [15:0]        z_sat;

  assign z_inc = {1'b0, rt_r_r[SQRT_STAGES-1][16:0]} + 18'd1;
  assign z_mag = z_inc[17:1];
  assign z_sat = (z_mag > Z_MAX) ? Z_MAX[15:0] : z_mag[15:0];

  // Scale by std_dev, then round and add the offset
  logic               p_vld_r;
  logic signed [15:0] p_z_r;
  logic signed [28:0] p_r;
  logic               o_vld_r;
  logic signed [15:0] o_z_r;
  logic signed [18:0] o_smp_r;
  logic [28:0]        p_abs;
  logic [28:0]        p_rnd;
  logic signed [19:0] q_s;
  logic signed [19:0] smp_sum;
  logic signed [18:0] smp_sat;

  assign p_abs   = p_r[28] ? 29'(-p_r) : p_r;
  assign p_rnd   = p_abs + 29'd2048;
  assign q_s     = p_r[28] ? -$signed({3'd0, p_rnd[28:12]}) : $signed({3'd0, p_rnd[28:12]});
  assign smp_sum = 20'(mean_offset) + q_s;

  always_comb begin
    priority if (smp_sum < SAMPLE_MIN) begin
      smp_sat = SAMPLE_MIN[18:0];
    end else if (smp_sum > SAMPLE_MAX) begin
      smp_sat = SAMPLE_MAX[18:0];
    end else begin
      smp_sat = smp_sum[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      z_vld_r <= rt_vld_r[SQRT_STAGES-1];
      p_vld_r <= z_vld_r;
      o_vld_r <= p_vld_r;
    end
    if (en) begin
      z_r     <= rt_neg_r[SQRT_STAGES-1] ? $signed(-z_sat) : $signed(z_sat);
      p_z_r   <= z_r;
      p_r     <= $signed({1'b0, std_dev}) * z_r;
      o_z_r   <= p_z_r;
      o_smp_r <= smp_sat;
    end
  end

  assign out_vld = o_vld_r;
  assign out_z   = o_z_r;
  assign out_smp = o_smp_r;

endmodule
`default_nettype wire

>>> design/polar_gaussian_sample_generator_unit.sv
// Top level of the polar Gaussian sample generator: front end, lanes, output buffer.
//
// Usage: each input transaction carries one pair of Q1.15 uniform values.
// A pair with s = a^2 + b^2 equal to zero or at least one is dropped with no
// output. An accepted pair gives two output transactions: the normal value
// from uniform_a, then the one from uniform_b with tlast high. Each holds
// unit_normal (Q4.12) and sample = mean_offset + round(std_dev * z).
// Pipeline: 2 front-end stages, 29 log stages (normalize, 24 squarings,
// ln 2 scaling), 52 lane stages (32-stage divider, 16-stage square root,
// rounding and scaling), then one output buffer. Throughput: a pair may
// enter every cycle while the pipeline is not held; the output port moves
// one result per cycle while out_tready is high, and the pipeline holds
// while the first result of each kept pair is sent.
// The whole pipeline holds while the output buffer is full; nothing is
// lost or repeated. Reset (rst_n low at a clock edge) empties the pipeline
// and loads std_dev = 50 and mean_offset = 250. Write the configuration
// registers only while the block is idle.
`default_nettype none
module polar_gaussian_sample_generator_unit import pgsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // uniform_a [15:0], uniform_b [31:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // unit_normal [15:0], sample [34:16], zero [39:35]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [17:0] cfg_wdata
);

  logic en;

  // Configuration registers
  logic [11:0]        std_dev_r;
  logic signed [17:0] mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_dev_r <= 12'd50;
      mean_r    <= 18'sd250;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STD_DEV: std_dev_r <= cfg_wdata[11:0];
        CFG_MEAN:    mean_r    <= $signed(cfg_wdata);
        default:     ;
      endcase
    end
  end

  // Front end: squares, then s and the accept test
  logic               f1_vld_r;
  logic signed [15:0] f1_a_r, f1_b_r;
  logic [30:0]        f1_sqa_r, f1_sqb_r;
  logic signed [31:0] pa, pb;
  logic               f2_vld_r;
  side_t              f2_side_r;
  logic [31:0]        s_sum;

  assign pa    = $signed(in_tdata[15:0]) * $signed(in_tdata[15:0]);
  assign pb    = $signed(in_tdata[31:16]) * $signed(in_tdata[31:16]);
  assign s_sum = {1'b0, f1_sqa_r} + {1'b0, f1_sqb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_tvalid;
      f2_vld_r <= f1_vld_r && (s_sum != 32'd0) && (s_sum[31:30] == 2'd0);
    end
    if (en) begin
      f1_a_r          <= $signed(in_tdata[15:0]);
      f1_b_r          <= $signed(in_tdata[31:16]);
      f1_sqa_r        <= pa[30:0];
      f1_sqb_r        <= pb[30:0];
      f2_side_r.sq_a  <= f1_sqa_r[29:0];
      f2_side_r.sq_b  <= f1_sqb_r[29:0];
      f2_side_r.neg_a <= f1_a_r[15];
      f2_side_r.neg_b <= f1_b_r[15];
      f2_side_r.s     <= s_sum[29:0];
    end
  end

  // Logarithm pipeline
  logic        lg_vld;
  side_t       lg_side;
  logic [28:0] lg_l;

  pgsg_log u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f2_vld_r),
    .in_side  (f2_side_r),
    .out_vld  (lg_vld),
    .out_side (lg_side),
    .out_l    (lg_l)
  );

  // Two lanes, one per component
  logic               la_vld, lb_vld;
  logic signed [15:0] la_z, lb_z;
  logic signed [18:0] la_smp, lb_smp;

  pgsg_lane u_lane_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (lg_vld),
    .in_sq       (lg_side.sq_a),
    .in_neg      (lg_side.neg_a),
    .in_s        (lg_side.s),
    .in_l        (lg_l),
    .std_dev     (std_dev_r),
    .mean_offset (mean_r),
    .out_vld     (la_vld),
    .out_z       (la_z),
    .out_smp     (la_smp)
  );

  pgsg_lane u_lane_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (lg_vld),
    .in_sq       (lg_side.sq_b),
    .in_neg      (lg_side.neg_b),
    .in_s        (lg_side.s),
    .in_l        (lg_l),
    .std_dev     (std_dev_r),
    .mean_offset (mean_r),
    .out_vld     (lb_vld),
    .out_z       (lb_z),
    .out_smp     (lb_smp)
  );

  // Output buffer holds one pair and sends it as two transactions
  logic               ob_vld_r;
  logic               ob_ph_r;
  logic signed [15:0] ob_za_r, ob_zb_r;
  logic signed [18:0] ob_sa_r, ob_sb_r;

  assign en = !ob_vld_r || (ob_ph_r && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_vld_r <= 1'b0;
      ob_ph_r  <= 1'b0;
    end else if (en) begin
      ob_vld_r <= la_vld && lb_vld;
      ob_ph_r  <= 1'b0;
    end else if (out_tready) begin
      ob_ph_r  <= 1'b1;
    end
    if (en) begin
      ob_za_r <= la_z;
      ob_sa_r <= la_smp;
      ob_zb_r <= lb_z;
      ob_sb_r <= lb_smp;
    end
  end

  // Refuse input while reset is held
  assign in_tready  = en && rst_n;
  assign out_tvalid = ob_vld_r;
  assign out_tlast  = ob_ph_r;
  assign out_tdata  = ob_ph_r ? {5'd0, ob_sb_r, ob_zb_r} : {5'd0, ob_sa_r, ob_za_r};

endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for the polar Gaussian sample generator: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
  import pgsg_pkg::*;

  typedef struct packed {
    logic signed [15:0] unit_normal;
    logic signed [18:0] sample;
    logic               last;
  } normal_result_t;

  // Predicts the normal values of each accepted pair and checks the output stream
  class normal_scoreboard;
    normal_result_t pending_q[$];
    int unsigned    std_dev;
    int             mean_offset;
    int             mismatches;

    function new();
      std_dev     = 50;
      mean_offset = 250;
      mismatches  = 0;
    endfunction

    function void write_reg(logic idx, logic [17:0] wdata);
      if (idx == CFG_STD_DEV) std_dev = {20'd0, wdata[11:0]};
      else mean_offset = int'($signed(wdata));
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function normal_result_t one_value(longint signed x, longint unsigned s,
                                       longint unsigned ln, logic last);
      normal_result_t  res;
      longint unsigned ax;
      longint unsigned y;
      longint unsigned mag;
      longint signed   z;
      longint signed   p;
      longint signed   q;
      longint signed   smp;
      ax  = (x < 0) ? -x : x;
      y   = (ax * ax * 64'd8 * ln) / s;
      mag = (int_sqrt(y) + 1) >> 1;
      if (mag > 32767) mag = 32767;
      z   = (x < 0) ? -longint'(mag) : longint'(mag);
      p   = longint'(std_dev) * z;
      q   = ((p < 0 ? -p : p) + 2048) >>> 12;
      if (p < 0) q = -q;
      smp = longint'(mean_offset) + q;
      if (smp < -262144) smp = -262144;
      if (smp > 262143) smp = 262143;
      res.unit_normal = z[15:0];
      res.sample      = smp[18:0];
      res.last        = last;
      return res;
    endfunction

    // Note an accepted pair; drop it when s is zero or at least one
    function void note_pair(logic signed [15:0] ua, logic signed [15:0] ub);
      longint signed   a;
      longint signed   b;
      longint unsigned s;
      longint unsigned m;
      longint unsigned g;
      longint unsigned ln;
      int unsigned     f;
      int              k;
      a = ua;
      b = ub;
      s = a * a + b * b;
      if (s == 0 || s >= (64'd1 << 30)) return;
      k = 0;
      while (k < 29 && (s >> (k + 1)) != 0) k++;
      m = s << (30 - k);
      f = 0;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        f = f << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          f = f | 1;
        end
      end
      g  = (longint'(30 - k) << 24) - longint'(f);
      ln = (g * longint'(LN2_Q30) + (64'd1 << 29)) >> 30;
      pending_q.push_back(one_value(a, s, ln, 1'b0));
      pending_q.push_back(one_value(b, s, ln, 1'b1));
    endfunction

    function void check_result(logic [39:0] data, logic last);
      normal_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h last=%b", data, last);
        return;
      end
      want = pending_q.pop_front();
      if (data[15:0] !== want.unit_normal || data[34:16] !== want.sample ||
          data[39:35] !== 5'd0 || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected z=%0d sample=%0d last=%b, ",
                    "got z=%0d sample=%0d last=%b pad=%h"},
                   want.unit_normal, want.sample, want.last, $signed(data[15:0]),
                   $signed(data[34:16]), last, data[39:35]);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_idx;
  logic [17:0] cfg_wdata;

  normal_scoreboard sb = new();
  int unsigned      cycle_count;
  int               hold_req;
  int               hold_left;
  int               rx_mode;
  int               rx_count;

  polar_gaussian_sample_generator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Stall the output on a changing pattern, or hold off for a long stretch on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    rx_count++;
    if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        2: out_tready = 1'($urandom_range(0, 1));
        default: out_tready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offer one pair and hold it until accepted; return at the falling edge after
  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    in_tvalid = 1'b1;
    in_tdata  = {b, a};
    do @(posedge clk); while (!in_tready);
    sb.note_pair(a, b);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_cfg(logic idx, logic [17:0] wdata);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = wdata;
    sb.write_reg(idx, wdata);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Wait for every expected result, then let dropped pairs drain
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Mostly kept pairs, some tiny ones for the tails, some raw noise
  task automatic random_pair(output logic [15:0] a, output logic [15:0] b);
    int sel;
    longint s;
    sel = $urandom_range(0, 9);
    a = 16'($urandom);
    b = 16'($urandom);
    if (sel == 1) begin
      a = $signed(a) >>> $urandom_range(6, 15);
      b = $signed(b) >>> $urandom_range(6, 15);
    end else if (sel > 1) begin
      s = longint'($signed(a)) * $signed(a) + longint'($signed(b)) * $signed(b);
      while (s == 0 || s >= (64'd1 << 30)) begin
        a = 16'($urandom);
        b = 16'($urandom);
        s = longint'($signed(a)) * $signed(a) + longint'($signed(b)) * $signed(b);
      end
    end
  endtask

  task automatic random_run(int n, bit steady);
    logic [15:0] a;
    logic [15:0] b;
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      random_pair(a, b);
      send_pair(a, b);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if (!steady) idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    logic [15:0] dir_a[$];
    logic [15:0] dir_b[$];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_STD_DEV;
    cfg_wdata   = '0;
    cycle_count = 0;
    hold_req    = 0;
    hold_left   = 0;
    rx_mode     = 0;
    rx_count    = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: rejected pairs, extremes, zero components, tiny values, the unit circle edge
    dir_a = '{16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'h8001, 16'h0000,
              16'h0001, 16'h0001, 16'hFFFF, 16'h0064, 16'h5A82, 16'h5A82, 16'h4E20,
              16'h0000, 16'h1234, 16'hF000, 16'h0002, 16'h7FFF, 16'hC000};
    dir_b = '{16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0001,
              16'h0000, 16'h0001, 16'hFFFF, 16'hFF9C, 16'h5A82, 16'h5A81, 16'hEC78,
              16'h8001, 16'hEDCC, 16'h0FFF, 16'hFFFE, 16'h7FFF, 16'h4000};
    foreach (dir_a[i]) begin
      send_pair(dir_a[i], dir_b[i]);
      idle_gap($urandom_range(0, 2));
    end
    random_run(200, 1'b0);
    drain();

    // Extreme high settings; hold the output off while the input keeps streaming
    write_cfg(CFG_STD_DEV, 18'd4095);
    write_cfg(CFG_MEAN, 18'h1FFFF);
    @(posedge clk);
    hold_req = 400;
    @(negedge clk);
    random_run(150, 1'b1);
    random_run(70, 1'b0);
    drain();

    // High scale with unused upper bits set, lowest mean
    write_cfg(CFG_STD_DEV, 18'h3FFFF);
    write_cfg(CFG_MEAN, 18'h20000);
    random_run(110, 1'b0);
    // Pause until every expected result is back
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    random_run(110, 1'b0);
    drain();

    // Zero scale and zero mean
    write_cfg(CFG_STD_DEV, 18'd0);
    write_cfg(CFG_MEAN, 18'd0);
    random_run(210, 1'b0);
    drain();

    // Random settings
    write_cfg(CFG_STD_DEV, 18'($urandom));
    write_cfg(CFG_MEAN, 18'($urandom));
    random_run(220, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
